// ===== design/spm_pkg.sv =====
package spm_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int FREQ_W    = 24;
    localparam int PAYLOAD_W = 64;
    localparam int TOL_W     = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd240;

    localparam logic MODE_AND = 1'b0;
    localparam logic MODE_OR  = 1'b1;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_TOL  = 1'b1
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic             mode;
        logic [TOL_W-1:0] tol;
    } cfg_t;

    function automatic logic within_tol(
        input logic [FREQ_W-1:0] a,
        input logic [FREQ_W-1:0] b,
        input logic [TOL_W-1:0]  tol
    );
        logic [FREQ_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return diff <= {{(FREQ_W-TOL_W){1'b0}}, tol};
    endfunction

endpackage

// ===== design/spm_regs.sv =====
module spm_regs
    import spm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_MODE: cfg_next.mode = pwdata[0];
                REG_TOL:  cfg_next.tol  = pwdata[TOL_W-1:0];
                default:  cfg_next      = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE: prdata = {{(APB_DW-1){1'b0}}, cfg_reg.mode};
            REG_TOL:  prdata = {{(APB_DW-TOL_W){1'b0}}, cfg_reg.tol};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= MODE_AND;
            cfg_reg.tol  <= TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/spm_ref_mem.sv =====
module spm_ref_mem
    import spm_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [FREQ_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [FREQ_W-1:0] rd_data
);

    logic [FREQ_W-1:0] mem [DEPTH];
    logic [FREQ_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== design/spm_ctrl.sv =====
module spm_ctrl
    import spm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 start,
    input  logic                 frame_start,
    input  logic                 from_second_list,
    input  logic [FREQ_W-1:0]    peak_frequency,
    input  logic [PAYLOAD_W-1:0] peak_payload,
    output logic                 busy,
    output logic                 done,
    output logic [FREQ_W-1:0]    merged_frequency,
    output logic [PAYLOAD_W-1:0] merged_payload,
    output logic                 came_from_second,
    output logic                 store_overflow,
    output logic                 mem_wr_en,
    output logic [AW-1:0]        mem_wr_addr,
    output logic [FREQ_W-1:0]    mem_wr_data,
    output logic                 mem_rd_en,
    output logic [AW-1:0]        mem_rd_addr,
    input  logic [FREQ_W-1:0]    mem_rd_data
);

    state_t                 state_reg,   state_next;
    logic [CW-1:0]          count_reg,   count_next;
    logic [CW-1:0]          idx_reg,     idx_next;
    logic [FREQ_W-1:0]      freq_reg,    freq_next;
    logic [PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic                   done_reg,    done_next;
    logic [FREQ_W-1:0]      ofreq_reg,   ofreq_next;
    logic [PAYLOAD_W-1:0]   opay_reg,    opay_next;
    logic                   osec_reg,    osec_next;
    logic                   oovf_reg,    oovf_next;

    logic [CW-1:0] eff_count;
    logic          accept;
    logic          hit;
    logic          scan_end;

    assign busy             = (state_reg != ST_IDLE);
    assign accept           = start && (state_reg == ST_IDLE);
    assign eff_count        = frame_start ? '0 : count_reg;
    assign hit              = within_tol(mem_rd_data, freq_reg, cfg.tol);
    assign scan_end         = hit || (idx_reg == count_reg);
    assign mem_wr_addr      = eff_count[AW-1:0];
    assign mem_wr_data      = peak_frequency;

    assign done             = done_reg;
    assign merged_frequency = ofreq_reg;
    assign merged_payload   = opay_reg;
    assign came_from_second = osec_reg;
    assign store_overflow   = oovf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !from_second_list && (eff_count != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        freq_next    = freq_reg;
        payload_next = payload_reg;
        done_next    = 1'b0;
        ofreq_next   = ofreq_reg;
        opay_next    = opay_reg;
        osec_next    = osec_reg;
        oovf_next    = oovf_reg;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    freq_next    = peak_frequency;
                    payload_next = peak_payload;
                    ofreq_next   = peak_frequency;
                    opay_next    = peak_payload;
                    osec_next    = from_second_list;
                    oovf_next    = 1'b0;
                    count_next   = eff_count;
                    if (from_second_list)
                    begin
                        done_next = (cfg.mode == MODE_OR);
                        if (eff_count < CW'(CAPACITY))
                        begin
                            mem_wr_en  = 1'b1;
                            count_next = eff_count + CW'(1);
                        end
                        else
                        begin
                            oovf_next = 1'b1;
                        end
                    end
                    else if (eff_count == '0)
                    begin
                        // empty store, never a match
                        done_next = (cfg.mode == MODE_OR);
                    end
                    else
                    begin
                        mem_rd_en = 1'b1;
                        idx_next  = CW'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    done_next  = (cfg.mode == MODE_AND) ? hit : !hit;
                    ofreq_next = freq_reg;
                    opay_next  = payload_reg;
                    osec_next  = 1'b0;
                    oovf_next  = 1'b0;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[AW-1:0];
                    idx_next    = idx_reg + CW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg    <= freq_next;
        payload_reg <= payload_next;
        ofreq_reg   <= ofreq_next;
        opay_reg    <= opay_next;
        osec_reg    <= osec_next;
        oovf_reg    <= oovf_next;
    end

endmodule

// ===== design/spectral_peak_list_merge.sv =====
// channel   signals                                              direction
// request   start, frame_start, from_second_list,                in
//           peak_frequency, peak_payload; busy is out
// result    done, merged_frequency, merged_payload,              out
//           came_from_second, store_overflow
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready apb
//
// reference peak: busy stays low, result in the cycle after the request
// candidate peak: one memory read per stored entry, stopping at the first match;
//   result in the cycle after the last compare
// reset clears the entry count and sets AND mode, tolerance 240; no memory clear
// results show for one cycle on done; the receiver cannot stall
module spectral_peak_list_merge
    import spm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic                 frame_start,
    input  logic                 from_second_list,
    input  logic [FREQ_W-1:0]    peak_frequency,
    input  logic [PAYLOAD_W-1:0] peak_payload,
    output logic                 done,
    output logic [FREQ_W-1:0]    merged_frequency,
    output logic [PAYLOAD_W-1:0] merged_payload,
    output logic                 came_from_second,
    output logic                 store_overflow
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    cfg_t              cfg;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [FREQ_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [FREQ_W-1:0] mem_rd_data;

    spm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spm_ref_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    spm_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .start            (start),
        .frame_start      (frame_start),
        .from_second_list (from_second_list),
        .peak_frequency   (peak_frequency),
        .peak_payload     (peak_payload),
        .busy             (busy),
        .done             (done),
        .merged_frequency (merged_frequency),
        .merged_payload   (merged_payload),
        .came_from_second (came_from_second),
        .store_overflow   (store_overflow),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data)
    );

endmodule
